[hdl/scrc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scrc_pkg: shared types and constants for the single-cycle RISC subset core
// Queue item layout, result word layout, decode codes and reset values.
// ----------------------------------------------------------------------------
package scrc_pkg;

  // Register file geometry
  localparam int unsigned REG_WORDS = 32;
  localparam int unsigned REG_AW    = 5;

  // Special registers
  localparam logic [REG_AW-1:0] SP_INDEX   = 5'd29;
  localparam logic [REG_AW-1:0] LINK_INDEX = 5'd31;
  localparam logic [31:0]       SP_RESET   = 32'd32;

  // Input func codes
  localparam logic [1:0] FUNC_LOAD_INSTR = 2'd0;
  localparam logic [1:0] FUNC_EXEC       = 2'd1;
  localparam logic [1:0] FUNC_READ_REG   = 2'd2;
  localparam logic [1:0] FUNC_READ_DATA  = 2'd3;

  // Opcode that carries R-type instructions
  localparam logic [5:0] OP_RTYPE = 6'd0;

  // Kind of a queued word, set by the front end
  typedef enum logic [1:0] {
    KIND_LOAD_INSTR,
    KIND_EXEC,
    KIND_READ_REG,
    KIND_READ_DATA
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [4:0]  addr;
    logic [31:0] word;
  } q_item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  // Result word, fields from the lowest bit up: pc, halted, read_data,
  // wrote_register, written_register, register_value, wrote_memory,
  // memory_index, memory_value, zero pad
  typedef struct packed {
    logic [2:0]  pad;
    logic [31:0] memory_value;
    logic [4:0]  memory_index;
    logic        wrote_memory;
    logic [31:0] register_value;
    logic [4:0]  written_register;
    logic        wrote_register;
    logic [31:0] read_data;
    logic        halted;
    logic [31:0] pc;
  } out_word_t;

  // Value of a register entry that was never written
  function automatic logic [31:0] reg_reset_value(input logic [REG_AW-1:0] idx);
    return (idx == SP_INDEX) ? SP_RESET : 32'd0;
  endfunction

endpackage
`default_nettype wire

[hdl/scrc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scrc_front: input side of the core
// Accepts stream words, classifies them by func and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module scrc_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [39:0]      s_axis_tdata,   // address[4:0], word[36:5], zero pad
  input  wire logic [1:0]       s_axis_tuser,   // func[1:0]
  output scrc_pkg::q_head_t     head_o,
  input  wire logic             pop_i
);
  import scrc_pkg::*;

  q_item_t    entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;
  kind_e      kind;
  q_item_t    item;

  // Classify the incoming word
  always_comb begin
    unique case (s_axis_tuser)
      FUNC_LOAD_INSTR: kind = KIND_LOAD_INSTR;
      FUNC_EXEC:       kind = KIND_EXEC;
      FUNC_READ_REG:   kind = KIND_READ_REG;
      FUNC_READ_DATA:  kind = KIND_READ_DATA;
      default:         kind = KIND_EXEC;
    endcase
    item.kind = kind;
    item.addr = s_axis_tdata[4:0];
    item.word = s_axis_tdata[36:5];
  end

  assign s_axis_tready = (count_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;

  // Queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (!push && pop_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = entry_q[rd_ptr_q];

endmodule
`default_nettype wire

[hdl/scrc_regfile.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scrc_regfile: 32-entry register file
// One write port, two registered read ports. Per-entry valid bits give the
// reset contents (register 29 holds 32, all others 0) without a sweep.
// ----------------------------------------------------------------------------
module scrc_regfile (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_en_i,
  input  wire logic [scrc_pkg::REG_AW-1:0] wr_addr_i,
  input  wire logic [31:0]                 wr_data_i,
  input  wire logic                        rd_en_i,
  input  wire logic [scrc_pkg::REG_AW-1:0] rd_addr_a_i,
  input  wire logic [scrc_pkg::REG_AW-1:0] rd_addr_b_i,
  output logic [31:0]                      rd_data_a_o,
  output logic [31:0]                      rd_data_b_o
);
  import scrc_pkg::*;

  logic [31:0]          mem_q [REG_WORDS];
  logic [REG_WORDS-1:0] vld_q;
  logic [31:0]          rd_a_q, rd_b_q;

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Written marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // Registered reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= vld_q[rd_addr_a_i] ? mem_q[rd_addr_a_i] : reg_reset_value(rd_addr_a_i);
      rd_b_q <= vld_q[rd_addr_b_i] ? mem_q[rd_addr_b_i] : reg_reset_value(rd_addr_b_i);
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule
`default_nettype wire

[hdl/scrc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scrc_back: execution side of the core
// Issues queued words into an execute stage (fetch, register read), then
// decodes, runs the ALU, accesses data memory, retires and registers the
// result word.
// ----------------------------------------------------------------------------
module scrc_back #(
  parameter int unsigned IMEM_WORDS = 32,
  parameter int unsigned DMEM_WORDS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [5:0]           cfg_wdata_i,
  input  wire scrc_pkg::q_head_t    head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output scrc_pkg::out_word_t       out_word_o
);
  import scrc_pkg::*;

  localparam int unsigned IAW = $clog2(IMEM_WORDS);
  localparam int unsigned DAW = $clog2(DMEM_WORDS);

  // Architectural state
  logic [31:0]           pc_q;
  logic [5:0]            len_q;
  logic [31:0]           imem_q [IMEM_WORDS];
  logic [IMEM_WORDS-1:0] imem_vld_q;
  logic [31:0]           dmem_q [DMEM_WORDS];
  logic [DMEM_WORDS-1:0] dmem_vld_q;

  // Execute stage
  logic        s2_valid_q;
  kind_e       s2_kind_q;
  logic [4:0]  s2_addr_q;
  logic [31:0] s2_ins_q;
  logic        s2_active_q;

  // Output register
  logic        out_valid_q;
  out_word_t   out_q;

  logic        s2_adv, s2_free, hazard, issue;
  logic [31:0] fetch_ins;
  logic [REG_AW-1:0] rf_ra, rf_rb;
  logic [31:0] rs_data, rt_data;
  logic        rf_we;
  logic [REG_AW-1:0] rf_waddr;
  logic [31:0] rf_wdata;
  logic [IAW-1:0] fetch_idx;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= 6'd0;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  // Issue control: pc and registers settle only when an execute retires
  always_comb begin
    s2_adv  = s2_valid_q && (!out_valid_q || out_ready_i);
    s2_free = !s2_valid_q || s2_adv;
    hazard  = s2_valid_q && (s2_kind_q == KIND_EXEC) &&
              ((head_i.item.kind == KIND_EXEC) || (head_i.item.kind == KIND_READ_REG));
    issue   = head_i.valid && s2_free && !hazard;
  end
  assign pop_o = issue;

  // Instruction fetch at the current pc
  assign fetch_idx = pc_q[IAW-1:0];
  assign fetch_ins = imem_vld_q[fetch_idx] ? imem_q[fetch_idx] : 32'd0;

  // Register read addresses
  assign rf_ra = (head_i.item.kind == KIND_READ_REG) ? head_i.item.addr : fetch_ins[25:21];
  assign rf_rb = fetch_ins[20:16];

  scrc_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (rf_we),
    .wr_addr_i   (rf_waddr),
    .wr_data_i   (rf_wdata),
    .rd_en_i     (issue),
    .rd_addr_a_i (rf_ra),
    .rd_addr_b_i (rf_rb),
    .rd_data_a_o (rs_data),
    .rd_data_b_o (rt_data)
  );

  // Instruction store, written at issue
  always_ff @(posedge clk_i) begin
    if (issue && (head_i.item.kind == KIND_LOAD_INSTR)) begin
      imem_q[head_i.item.addr[IAW-1:0]] <= head_i.item.word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imem_vld_q <= '0;
    end else if (issue && (head_i.item.kind == KIND_LOAD_INSTR)) begin
      imem_vld_q[head_i.item.addr[IAW-1:0]] <= 1'b1;
    end
  end

  // Execute stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (issue) begin
      s2_valid_q <= 1'b1;
    end else if (s2_adv) begin
      s2_valid_q <= 1'b0;
    end
  end

  // Execute stage payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s2_kind_q   <= head_i.item.kind;
      s2_addr_q   <= head_i.item.addr;
      s2_ins_q    <= fetch_ins;
      s2_active_q <= (head_i.item.kind == KIND_EXEC) && (pc_q < 32'(len_q));
    end
  end

  // Decode
  logic [5:0]  op;
  logic        o0, o1, o2, o3, o5, f0, f1, f2, f3, f5;
  logic        alusrc, memwrite, memread, jump, link, branch, regdst, regwrite;
  logic        aluop0, aluop1, c0, c1, c2, ret;
  logic [31:0] sx;
  logic        exec_en;

  always_comb begin
    op = s2_ins_q[31:26];
    o0 = op[0];
    o1 = op[1];
    o2 = op[2];
    o3 = op[3];
    o5 = op[5];
    f0 = s2_ins_q[0];
    f1 = s2_ins_q[1];
    f2 = s2_ins_q[2];
    f3 = s2_ins_q[3];
    f5 = s2_ins_q[5];
    sx = {{16{s2_ins_q[15]}}, s2_ins_q[15:0]};
    alusrc   = o5 | o3;
    memwrite = o5 & o3;
    memread  = o5 & ~o3;
    jump     = o1 & ~o5;
    link     = o0 & o1 & ~o5;
    branch   = o2;
    regdst   = ~(o5 ^ o3);
    regwrite = ~(o2 | (o1 & ~o5) | (o5 & o3)) | link;
    aluop0   = o2;
    aluop1   = ~(o3 | o2 | o5);
    c1       = ~(aluop1 & f2);
    c2       = aluop0 | (aluop1 & f1);
    c0       = aluop1 & (f0 | (f3 & f5));
    ret      = (op == OP_RTYPE) & f3 & ~f5;
    exec_en  = (s2_kind_q == KIND_EXEC) && s2_active_q;
  end

  // ALU
  logic [31:0] in2, bb, sum, res_pre, res;
  logic        zero;

  always_comb begin
    in2 = alusrc ? sx : rt_data;
    bb  = c2 ? ~in2 : in2;
    sum = rs_data + bb + {31'd0, c2};
    if (c1 && c0) begin
      res_pre = 32'd0;
    end else if (c1) begin
      res_pre = sum;
    end else if (c0) begin
      res_pre = rs_data | bb;
    end else begin
      res_pre = rs_data & bb;
    end
    zero = (res_pre == 32'd0);
    res  = (c1 && c0) ? {31'd0, sum[31]} : res_pre;
  end

  // Data memory access
  logic [DAW-1:0] dmem_idx;
  logic [31:0]    dmem_rd;
  logic           dmem_we;

  assign dmem_idx = (s2_kind_q == KIND_READ_DATA) ? s2_addr_q[DAW-1:0] : res[DAW-1:0];
  assign dmem_rd  = dmem_vld_q[dmem_idx] ? dmem_q[dmem_idx] : 32'd0;
  assign dmem_we  = s2_adv && exec_en && memwrite;

  always_ff @(posedge clk_i) begin
    if (dmem_we) begin
      dmem_q[dmem_idx] <= rt_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmem_vld_q <= '0;
    end else if (dmem_we) begin
      dmem_vld_q[dmem_idx] <= 1'b1;
    end
  end

  // Write back and next pc
  logic [31:0] npc, newpc, pc_out;
  logic        reg_wr;

  always_comb begin
    npc      = pc_q + 32'd1;
    rf_wdata = link ? npc : (memread ? dmem_rd : res);
    rf_waddr = link ? LINK_INDEX : (regdst ? s2_ins_q[15:11] : s2_ins_q[20:16]);
    reg_wr   = exec_en && regwrite && !ret;
    rf_we    = s2_adv && reg_wr;
    newpc    = npc;
    if (branch && zero) newpc = npc + sx;
    if (jump) newpc = {newpc[31:26], s2_ins_q[25:0]};
    if (ret && !jump) newpc = res;
    pc_out   = exec_en ? newpc : pc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= 32'd0;
    end else if (s2_adv && exec_en) begin
      pc_q <= newpc;
    end
  end

  // Result word
  out_word_t res_word;

  always_comb begin
    res_word.pad              = '0;
    res_word.pc               = pc_out;
    res_word.halted           = !(pc_out < 32'(len_q));
    case (s2_kind_q)
      KIND_READ_REG:  res_word.read_data = rs_data;
      KIND_READ_DATA: res_word.read_data = dmem_rd;
      default:        res_word.read_data = 32'd0;
    endcase
    res_word.wrote_register   = reg_wr;
    res_word.written_register = reg_wr ? rf_waddr : 5'd0;
    res_word.register_value   = reg_wr ? rf_wdata : 32'd0;
    res_word.wrote_memory     = exec_en && memwrite;
    res_word.memory_index     = (exec_en && memwrite) ? 5'(dmem_idx) : 5'd0;
    res_word.memory_value     = (exec_en && memwrite) ? rt_data : 32'd0;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire

[hdl/single_cycle_risc_subset_cpu_unit.sv]
`default_nettype none
// Path: an accepted word passes the front queue, the execute stage and the output register.
// Throughput: one word per cycle while the output is taken; an execute or register read that
// directly follows an execute waits until that execute retires, since pc and register file update at retire.
// Reset: asynchronous, active low; pc, program_length and all three stores read as
// their reset contents at once through per-entry written marks, no clearing pass.
// ----------------------------------------------------------------------------
// single_cycle_risc_subset_cpu_unit: MIPS-like subset core, stream wrapper
// Front queue classifies words, back end executes and returns one result each.
// ----------------------------------------------------------------------------
module single_cycle_risc_subset_cpu_unit #(
  parameter int unsigned IMEM_WORDS = 32,
  parameter int unsigned DMEM_WORDS = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [5:0]   cfg_wdata_i,    // program_length
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [39:0]  s_axis_tdata,   // address[4:0], word[36:5], zero pad
  input  wire logic [1:0]   s_axis_tuser,   // func[1:0]
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [143:0]      m_axis_tdata    // pc[31:0], halted[32], read_data[64:33],
                                            // wrote_register[65], written_register[70:66],
                                            // register_value[102:71], wrote_memory[103],
                                            // memory_index[108:104], memory_value[140:109],
                                            // zero pad
);
  import scrc_pkg::*;

  q_head_t   head;
  logic      pop;
  out_word_t out_word;

  scrc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .head_o        (head),
    .pop_i         (pop)
  );

  scrc_back #(
    .IMEM_WORDS (IMEM_WORDS),
    .DMEM_WORDS (DMEM_WORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_word_o  (out_word)
  );

  assign m_axis_tdata = out_word;

endmodule
`default_nettype wire
